[rtl/ccm_pkg.sv]
// ----------------------------------------------------------------------------
// ccm_pkg: shared types and constants for the cylinder collision core
// Request and result structs, plus the side data carried through the square
// root and divider pipelines.
// ----------------------------------------------------------------------------
package ccm_pkg;

  // Coordinate width; lengths are one bit narrower and unsigned.
  localparam int CW  = 32;
  localparam int LW  = CW - 1;
  // Width of the integer square root of the squared xz distance.
  localparam int SW  = CW + 1;
  // Width of the squared xz distance.
  localparam int D2W = 2 * CW + 1;

  typedef struct packed {
    logic signed [CW-1:0] a_pos_x;
    logic signed [CW-1:0] a_pos_y;
    logic signed [CW-1:0] a_pos_z;
    logic        [LW-1:0] a_radius;
    logic        [LW-1:0] a_height;
    logic                 a_fixed;
    logic signed [CW-1:0] b_pos_x;
    logic signed [CW-1:0] b_pos_y;
    logic signed [CW-1:0] b_pos_z;
    logic        [LW-1:0] b_radius;
    logic        [LW-1:0] b_height;
    logic                 b_fixed;
  } ccm_req_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] a_move_x;
    logic signed [CW-1:0] a_move_y;
    logic signed [CW-1:0] a_move_z;
    logic signed [CW-1:0] b_move_x;
    logic signed [CW-1:0] b_move_y;
    logic signed [CW-1:0] b_move_z;
  } ccm_res_t;

  // Geometry that travels alongside the square root.
  typedef struct packed {
    logic                 hit;
    logic        [CW-1:0] radii;
    logic signed [CW+1:0] v;
    logic        [CW:0]   vabs;
    logic        [CW-1:0] mx;
    logic        [CW-1:0] mz;
    logic                 nx;
    logic                 nz;
    logic                 zero;
    logic                 af;
    logic                 bf;
  } ccm_geo_t;

  // Push selection data that travels alongside the divider.
  typedef struct packed {
    logic                 hit;
    logic                 vert;
    logic signed [CW+1:0] v;
    logic                 nx;
    logic                 nz;
    logic                 af;
    logic                 bf;
  } ccm_push_t;

endpackage

[rtl/ccm_sqrt_pipe.sv]
// ----------------------------------------------------------------------------
// ccm_sqrt_pipe: pipelined integer square root
// One result bit per stage, digit by digit without multipliers, floor result.
// ----------------------------------------------------------------------------
module ccm_sqrt_pipe (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [ccm_pkg::D2W-1:0] in_rad,
  input  ccm_pkg::ccm_geo_t   in_side,
  output logic                out_valid,
  output logic [ccm_pkg::SW-1:0]  out_root,
  output ccm_pkg::ccm_geo_t   out_side
);
  import ccm_pkg::*;

  localparam int OW = 2 * SW;
  localparam int RW = SW + 2;

  logic [SW:0]   vld;
  logic [OW-1:0] op   [SW+1];
  logic [RW-1:0] rem  [SW+1];
  logic [SW-1:0] root [SW+1];
  ccm_geo_t      side [SW+1];

  // Stage zero is the unregistered input.
  assign vld[0]  = in_valid;
  assign op[0]   = {{(OW-D2W){1'b0}}, in_rad};
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;

    // Bring down two operand bits and try the next root bit.
    always_comb begin
      rem_sh = {rem[k][RW-3:0], op[k][OW-1:OW-2]};
      trial  = {root[k], 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      op[k+1]   <= {op[k][OW-3:0], 2'b00};
      rem[k+1]  <= ge ? rem_sh - trial : rem_sh;
      root[k+1] <= {root[k][SW-2:0], ge};
      side[k+1] <= side[k];
    end
  end

  assign out_valid = vld[SW];
  assign out_root  = root[SW];
  assign out_side  = side[SW];

endmodule

[rtl/ccm_div_pipe.sv]
// ----------------------------------------------------------------------------
// ccm_div_pipe: pipelined restoring divider, two numerators, shared divisor
// One quotient bit per stage; the quotient is known to fit in CW bits.
// ----------------------------------------------------------------------------
module ccm_div_pipe (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [2*ccm_pkg::CW-1:0] in_num_x,
  input  logic [2*ccm_pkg::CW-1:0] in_num_z,
  input  logic [ccm_pkg::CW-1:0]   in_den,
  input  ccm_pkg::ccm_push_t   in_side,
  output logic                 out_valid,
  output logic [ccm_pkg::CW-1:0]   out_quo_x,
  output logic [ccm_pkg::CW-1:0]   out_quo_z,
  output ccm_pkg::ccm_push_t   out_side
);
  import ccm_pkg::*;

  logic [CW:0]   vld;
  logic [CW:0]   rem_x [CW+1];
  logic [CW:0]   rem_z [CW+1];
  logic [CW-1:0] low_x [CW+1];
  logic [CW-1:0] low_z [CW+1];
  logic [CW-1:0] den   [CW+1];
  ccm_push_t     side  [CW+1];

  // The upper half of each numerator is the starting remainder.
  assign vld[0]   = in_valid;
  assign rem_x[0] = {1'b0, in_num_x[2*CW-1:CW]};
  assign rem_z[0] = {1'b0, in_num_z[2*CW-1:CW]};
  assign low_x[0] = in_num_x[CW-1:0];
  assign low_z[0] = in_num_z[CW-1:0];
  assign den[0]   = in_den;
  assign side[0]  = in_side;

  for (genvar k = 0; k < CW; k++) begin : g_stage
    logic [CW:0] rs_x;
    logic [CW:0] rs_z;
    logic        ge_x;
    logic        ge_z;

    // Shift in the next numerator bit and subtract where it fits.
    always_comb begin
      rs_x = {rem_x[k][CW-1:0], low_x[k][CW-1]};
      rs_z = {rem_z[k][CW-1:0], low_z[k][CW-1]};
      ge_x = (rs_x >= {1'b0, den[k]});
      ge_z = (rs_z >= {1'b0, den[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      rem_x[k+1] <= ge_x ? rs_x - {1'b0, den[k]} : rs_x;
      rem_z[k+1] <= ge_z ? rs_z - {1'b0, den[k]} : rs_z;
      low_x[k+1] <= {low_x[k][CW-2:0], ge_x};
      low_z[k+1] <= {low_z[k][CW-2:0], ge_z};
      den[k+1]   <= den[k];
      side[k+1]  <= side[k];
    end
  end

  assign out_valid = vld[CW];
  assign out_quo_x = low_x[CW];
  assign out_quo_z = low_z[CW];
  assign out_side  = side[CW];

endmodule

[rtl/cylinder_collision_mtv_core.sv]
// ----------------------------------------------------------------------------
// cylinder_collision_mtv_core: upright cylinder collision and push vector
// Tests two cylinders for overlap and computes the shared separating push.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on req at any rising edge where start is high and busy
//   is low. busy is always low, so a new request may be issued every cycle.
//   Each request yields exactly one result on result, marked by done for one
//   cycle. The receiver cannot stall; it must take the result when done rises.
//   A request passes through stages 1 to 4, the bit-per-stage square root (CW+1
//   stages), stages 5 and 6, the bit-per-stage divider (CW stages), stage 7
//   and the output register that drives done. Throughput is one request per
//   cycle.
//   Reset clears every valid bit in the pipeline; requests in flight are
//   dropped and no result appears until a new request has passed through.
//   A miss gives hit low and all displacements zero. Displacements saturate
//   to the signed coordinate range.
// ----------------------------------------------------------------------------
module cylinder_collision_mtv_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ccm_pkg::ccm_req_t req,
  output logic              done,
  output ccm_pkg::ccm_res_t result
);
  import ccm_pkg::*;

  localparam int LAT = 2 * CW + 9;

  // Stage 1: differences and vertical extents.
  logic                 s1_v;
  logic signed [CW:0]   s1_dx, s1_dz;
  logic signed [CW-1:0] s1_ay, s1_by;
  logic signed [CW:0]   s1_ay1, s1_by1;
  logic        [CW-1:0] s1_radii;
  logic                 s1_af, s1_bf;

  // Stage 2: magnitudes, vertical overlap and margins.
  logic                 s2_v;
  logic        [CW-1:0] s2_mx, s2_mz;
  logic                 s2_nx, s2_nz, s2_zero, s2_yov;
  logic signed [CW+1:0] s2_m1, s2_m2;
  logic        [CW-1:0] s2_radii;
  logic                 s2_af, s2_bf;

  // Stage 3: squares.
  logic                 s3_v;
  logic      [2*CW-1:0] s3_sqx, s3_sqz, s3_r2;
  logic signed [CW+1:0] s3_vp;
  logic        [CW-1:0] s3_mx, s3_mz, s3_radii;
  logic                 s3_nx, s3_nz, s3_zero, s3_yov, s3_af, s3_bf;

  // Stage 4: squared distance and hit test.
  logic                 s4_v;
  logic       [D2W-1:0] s4_d2;
  ccm_geo_t             s4_geo;

  // Square root output.
  logic                 sq_v;
  logic        [SW-1:0] sq_root;
  ccm_geo_t             sq_geo;

  // Stage 5: radial depth.
  logic                 s5_v;
  logic        [CW-1:0] s5_depth, s5_dist;
  ccm_geo_t             s5_geo;

  // Stage 6: numerators and push choice.
  logic                 s6_v;
  logic      [2*CW-1:0] s6_numx, s6_numz;
  logic        [CW-1:0] s6_dist;
  ccm_push_t            s6_push;

  // Divider output.
  logic                 dv_v;
  logic        [CW-1:0] dv_qx, dv_qz;
  ccm_push_t            dv_push;

  // Stage 7: signed push vector.
  logic                 s7_v, s7_hit, s7_af, s7_bf;
  logic signed [CW+1:0] s7_px, s7_py, s7_pz;

  // Combinational helpers.
  logic signed [CW:0]   neg_dx, neg_dz;
  logic signed [CW+1:0] neg_m2, neg_vp;
  logic       [D2W-1:0] d2_sum;
  logic        [CW-1:0] qx_ext_unused;

  assign busy = 1'b0;

  // Halve toward zero.
  function automatic logic signed [CW+1:0] half_tz(input logic signed [CW+1:0] x);
    logic signed [CW+1:0] t;
    t = x + {{(CW+1){1'b0}}, x[CW+1]};
    return t >>> 1;
  endfunction

  // Clamp to the signed coordinate range.
  function automatic logic [CW-1:0] sat_cw(input logic signed [CW+1:0] x);
    logic ovf;
    ovf = !((x[CW+1] == x[CW]) && (x[CW] == x[CW-1]));
    if (ovf) begin
      return x[CW+1] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end
    return x[CW-1:0];
  endfunction

  // Share one push component between the bodies by their static flags.
  function automatic logic [2*CW-1:0] share(input logic signed [CW+1:0] p,
                                            input logic af, input logic bf);
    logic signed [CW+1:0] h, am, bm;
    h = half_tz(p);
    if (af && bf) begin
      am = '0;
      bm = '0;
    end else if (af) begin
      am = '0;
      bm = -p;
    end else if (bf) begin
      am = p;
      bm = '0;
    end else begin
      am = h;
      bm = -h;
    end
    return {sat_cw(am), sat_cw(bm)};
  endfunction

  assign neg_dx = -s1_dx;
  assign neg_dz = -s1_dz;
  assign neg_m2 = -s2_m2;
  assign neg_vp = -s3_vp;
  assign d2_sum = {1'b0, s3_sqx} + {1'b0, s3_sqz};
  assign qx_ext_unused = '0;

  // Stage 1.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= start && !busy;
    end
    s1_dx    <= {req.a_pos_x[CW-1], req.a_pos_x} - {req.b_pos_x[CW-1], req.b_pos_x};
    s1_dz    <= {req.a_pos_z[CW-1], req.a_pos_z} - {req.b_pos_z[CW-1], req.b_pos_z};
    s1_ay    <= req.a_pos_y;
    s1_by    <= req.b_pos_y;
    s1_ay1   <= {req.a_pos_y[CW-1], req.a_pos_y} + {2'b00, req.a_height};
    s1_by1   <= {req.b_pos_y[CW-1], req.b_pos_y} + {2'b00, req.b_height};
    s1_radii <= {1'b0, req.a_radius} + {1'b0, req.b_radius};
    s1_af    <= req.a_fixed;
    s1_bf    <= req.b_fixed;
  end

  // Stage 2.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    s2_mx    <= s1_dx[CW] ? neg_dx[CW-1:0] : s1_dx[CW-1:0];
    s2_mz    <= s1_dz[CW] ? neg_dz[CW-1:0] : s1_dz[CW-1:0];
    s2_nx    <= s1_dx[CW];
    s2_nz    <= s1_dz[CW];
    s2_zero  <= (s1_dx == '0) && (s1_dz == '0);
    s2_yov   <= ($signed({s1_ay[CW-1], s1_ay}) < s1_by1) &&
                ($signed({s1_by[CW-1], s1_by}) < s1_ay1);
    s2_m1    <= {s1_by1[CW], s1_by1} - {{2{s1_ay[CW-1]}}, s1_ay};
    s2_m2    <= {s1_ay1[CW], s1_ay1} - {{2{s1_by[CW-1]}}, s1_by};
    s2_radii <= s1_radii;
    s2_af    <= s1_af;
    s2_bf    <= s1_bf;
  end

  // Stage 3.
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else begin
      s3_v <= s2_v;
    end
    s3_sqx   <= s2_mx * s2_mx;
    s3_sqz   <= s2_mz * s2_mz;
    s3_r2    <= s2_radii * s2_radii;
    s3_vp    <= (s2_m1 < s2_m2) ? s2_m1 : neg_m2;
    s3_mx    <= s2_mx;
    s3_mz    <= s2_mz;
    s3_radii <= s2_radii;
    s3_nx    <= s2_nx;
    s3_nz    <= s2_nz;
    s3_zero  <= s2_zero;
    s3_yov   <= s2_yov;
    s3_af    <= s2_af;
    s3_bf    <= s2_bf;
  end

  // Stage 4.
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else begin
      s4_v <= s3_v;
    end
    s4_d2       <= d2_sum;
    s4_geo.hit  <= s3_yov && (d2_sum < {1'b0, s3_r2});
    s4_geo.radii <= s3_radii;
    s4_geo.v    <= s3_vp;
    s4_geo.vabs <= s3_vp[CW+1] ? neg_vp[CW:0] : s3_vp[CW:0];
    s4_geo.mx   <= s3_mx;
    s4_geo.mz   <= s3_mz;
    s4_geo.nx   <= s3_nx;
    s4_geo.nz   <= s3_nz;
    s4_geo.zero <= s3_zero;
    s4_geo.af   <= s3_af;
    s4_geo.bf   <= s3_bf;
  end

  ccm_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s4_v),
    .in_rad    (s4_d2),
    .in_side   (s4_geo),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_geo)
  );

  // Stage 5: depth is positive whenever the pair hits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else begin
      s5_v <= sq_v;
    end
    s5_depth <= sq_geo.radii - sq_root[CW-1:0];
    s5_dist  <= sq_root[CW-1:0];
    s5_geo   <= sq_geo;
  end

  // Stage 6: vertical wins on a tie or a zero offset.
  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else begin
      s6_v <= s5_v;
    end
    s6_numx      <= s5_depth * s5_geo.mx;
    s6_numz      <= s5_depth * s5_geo.mz;
    s6_dist      <= s5_dist;
    s6_push.hit  <= s5_geo.hit;
    s6_push.vert <= (s5_geo.vabs <= {1'b0, s5_depth}) || s5_geo.zero;
    s6_push.v    <= s5_geo.v;
    s6_push.nx   <= s5_geo.nx;
    s6_push.nz   <= s5_geo.nz;
    s6_push.af   <= s5_geo.af;
    s6_push.bf   <= s5_geo.bf;
  end

  ccm_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s6_v),
    .in_num_x  (s6_numx),
    .in_num_z  (s6_numz),
    .in_den    (s6_dist),
    .in_side   (s6_push),
    .out_valid (dv_v),
    .out_quo_x (dv_qx),
    .out_quo_z (dv_qz),
    .out_side  (dv_push)
  );

  // Stage 7: pick the vertical or the radial push and apply signs.
  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else begin
      s7_v <= dv_v;
    end
    s7_hit <= dv_push.hit;
    s7_af  <= dv_push.af;
    s7_bf  <= dv_push.bf;
    if (dv_push.vert) begin
      s7_px <= '0;
      s7_py <= dv_push.v;
      s7_pz <= '0;
    end else begin
      s7_px <= dv_push.nx ? -{2'b00, dv_qx} : {2'b00, dv_qx | qx_ext_unused};
      s7_py <= '0;
      s7_pz <= dv_push.nz ? -{2'b00, dv_qz} : {2'b00, dv_qz};
    end
  end

  // Output register: share, saturate and blank on a miss.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s7_v;
    end
    result.hit <= s7_hit;
    if (s7_hit) begin
      {result.a_move_x, result.b_move_x} <= share(s7_px, s7_af, s7_bf);
      {result.a_move_y, result.b_move_y} <= share(s7_py, s7_af, s7_bf);
      {result.a_move_z, result.b_move_z} <= share(s7_pz, s7_af, s7_bf);
    end else begin
      result.a_move_x <= '0;
      result.a_move_y <= '0;
      result.a_move_z <= '0;
      result.b_move_x <= '0;
      result.b_move_y <= '0;
      result.b_move_z <= '0;
    end
  end

  // A result only ever follows a request by the full pipeline latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching request");

  // A miss moves nothing.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.hit |-> result.a_move_x == '0 && result.a_move_y == '0 &&
      result.a_move_z == '0 && result.b_move_x == '0 && result.b_move_y == '0 &&
      result.b_move_z == '0)
    else $error("non-zero displacement on a miss");

  // The push is either vertical or radial, never both.
  a_axis_excl: assert property (@(posedge clk) disable iff (rst)
    done && result.a_move_y != '0 |-> result.a_move_x == '0 && result.a_move_z == '0)
    else $error("mixed vertical and radial push");

  // Two static bodies are never moved.
  a_both_static: assert property (@(posedge clk) disable iff (rst)
    s7_v && s7_af && s7_bf |=> done && result.a_move_x == '0 &&
      result.a_move_y == '0 && result.a_move_z == '0 && result.b_move_x == '0 &&
      result.b_move_y == '0 && result.b_move_z == '0)
    else $error("static pair was displaced");

endmodule

[tb/cylinder_collision_mtv_core_tb.sv]
// ----------------------------------------------------------------------------
// cylinder_collision_mtv_core_tb: self-checking bench for the collision core
// Drives directed and random cylinder pairs, predicts the hit flag and both
// displacement vectors with exact wide integer arithmetic, and compares every
// result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module cylinder_collision_mtv_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ccm_pkg::*;

  localparam int LATENCY = 2 * CW + 9;

  // Saturate a wide signed value to the coordinate range.
  function automatic logic signed [CW-1:0] clamp_coord(input logic signed [127:0] v);
    logic signed [127:0] hi;
    logic signed [127:0] lo;
    hi = (128'sd1 <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

  // Exact collision response for one cylinder pair.
  function automatic ccm_res_t predict_push(input ccm_req_t r);
    ccm_res_t res;
    logic signed [127:0] ax, ay, az, bx, by, bz, ar, ah, br, bh;
    logic signed [127:0] dx, dz, radii, m1, m2, v, vabs, depth, d2, root_d, cand;
    logic signed [127:0] push [3];
    logic signed [127:0] am, bm;
    res = '0;
    ax = r.a_pos_x; ay = r.a_pos_y; az = r.a_pos_z;
    bx = r.b_pos_x; by = r.b_pos_y; bz = r.b_pos_z;
    ar = {97'd0, r.a_radius}; ah = {97'd0, r.a_height};
    br = {97'd0, r.b_radius}; bh = {97'd0, r.b_height};
    if (!(ay < by + bh && by < ay + ah)) return res;
    dx = ax - bx;
    dz = az - bz;
    radii = ar + br;
    d2 = dx * dx + dz * dz;
    if (!(d2 < radii * radii)) return res;
    m1 = by + bh - ay;
    m2 = ay + ah - by;
    v = (m1 < m2) ? m1 : -m2;
    vabs = (v < 0) ? -v : v;
    root_d = 0;
    for (int b = 62; b >= 0; b--) begin
      cand = root_d | (128'sd1 <<< b);
      if (!(d2 < cand * cand)) root_d = cand;
    end
    depth = radii - root_d;
    push[0] = 0; push[1] = 0; push[2] = 0;
    if (vabs <= depth || (dx == 0 && dz == 0)) begin
      push[1] = v;
    end else begin
      // Signed division truncates toward zero, as the push requires.
      push[0] = (depth * dx) / root_d;
      push[2] = (depth * dz) / root_d;
    end
    res.hit = 1'b1;
    for (int i = 0; i < 3; i++) begin
      am = 0; bm = 0;
      if (r.a_fixed && r.b_fixed) begin
      end else if (r.a_fixed) begin
        bm = -push[i];
      end else if (r.b_fixed) begin
        am = push[i];
      end else begin
        am = push[i] / 2;
        bm = -(push[i] / 2);
      end
      case (i)
        0: begin res.a_move_x = clamp_coord(am); res.b_move_x = clamp_coord(bm); end
        1: begin res.a_move_y = clamp_coord(am); res.b_move_y = clamp_coord(bm); end
        default: begin res.a_move_z = clamp_coord(am); res.b_move_z = clamp_coord(bm); end
      endcase
    end
    return res;
  endfunction

  // Holds predicted responses in request order and checks arrivals.
  class push_scoreboard;
    ccm_res_t pending[$];
    int errors = 0;

    function void note_request(ccm_req_t r);
      pending.push_back(predict_push(r));
    endfunction

    function void check_result(ccm_res_t got);
      ccm_res_t exp;
      if (pending.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.hit !== exp.hit) begin
        $error("hit: expected %0d, got %0d", exp.hit, got.hit); errors++;
      end
      if (got.a_move_x !== exp.a_move_x) begin
        $error("a_move_x: expected %0d, got %0d", exp.a_move_x, got.a_move_x); errors++;
      end
      if (got.a_move_y !== exp.a_move_y) begin
        $error("a_move_y: expected %0d, got %0d", exp.a_move_y, got.a_move_y); errors++;
      end
      if (got.a_move_z !== exp.a_move_z) begin
        $error("a_move_z: expected %0d, got %0d", exp.a_move_z, got.a_move_z); errors++;
      end
      if (got.b_move_x !== exp.b_move_x) begin
        $error("b_move_x: expected %0d, got %0d", exp.b_move_x, got.b_move_x); errors++;
      end
      if (got.b_move_y !== exp.b_move_y) begin
        $error("b_move_y: expected %0d, got %0d", exp.b_move_y, got.b_move_y); errors++;
      end
      if (got.b_move_z !== exp.b_move_z) begin
        $error("b_move_z: expected %0d, got %0d", exp.b_move_z, got.b_move_z); errors++;
      end
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  ccm_req_t req = '0;
  logic     done;
  ccm_res_t result;

  push_scoreboard sb = new();
  int idle_pct = 0;

  cylinder_collision_mtv_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req(req), .done(done), .result(result)
  );

  always #5 clk = ~clk;

  // Note accepted requests and check results at each rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_request(req);
      if (done) sb.check_result(result);
    end
  end

  // Issue one request, with a random idle gap, and wait until it is taken.
  task automatic send_request(input ccm_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(8) == 0 ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $signed($urandom_range(8 << 16)) - (4 << 16);
    endcase
  endfunction

  function automatic logic [LW-1:0] rand_len();
    case ($urandom_range(4))
      0: return LW'($urandom());
      1: return '1;
      default: return LW'($urandom_range(6 << 16));
    endcase
  endfunction

  // Random pair; most are placed near each other so that they often touch.
  function automatic ccm_req_t rand_pair();
    ccm_req_t r;
    r.a_pos_x = rand_coord(); r.a_pos_y = rand_coord(); r.a_pos_z = rand_coord();
    r.a_radius = rand_len(); r.a_height = rand_len(); r.a_fixed = 1'($urandom());
    r.b_radius = rand_len(); r.b_height = rand_len(); r.b_fixed = 1'($urandom());
    if ($urandom_range(9) < 7) begin
      r.b_pos_x = r.a_pos_x + ($signed($urandom_range(6 << 16)) - (3 << 16));
      r.b_pos_y = r.a_pos_y + ($signed($urandom_range(6 << 16)) - (3 << 16));
      r.b_pos_z = ($urandom_range(4) == 0) ? r.a_pos_z
                : r.a_pos_z + ($signed($urandom_range(6 << 16)) - (3 << 16));
      if ($urandom_range(6) == 0) r.b_pos_x = r.a_pos_x;
    end else begin
      r.b_pos_x = rand_coord(); r.b_pos_y = rand_coord(); r.b_pos_z = rand_coord();
    end
    return r;
  endfunction

  function automatic ccm_req_t make_pair(input logic [31:0] ax, ay, az,
      input logic [LW-1:0] ar, ah, input logic af,
      input logic [31:0] bx, by, bz, input logic [LW-1:0] br, bh, input logic bf);
    ccm_req_t r;
    r.a_pos_x = ax; r.a_pos_y = ay; r.a_pos_z = az;
    r.a_radius = ar; r.a_height = ah; r.a_fixed = af;
    r.b_pos_x = bx; r.b_pos_y = by; r.b_pos_z = bz;
    r.b_radius = br; r.b_height = bh; r.b_fixed = bf;
    return r;
  endfunction

  // Stimulus: directed corners, then random pairs under three idling phases.
  initial begin
    int waited;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Coincident bases: vertical push is forced, all static combinations.
    for (int f = 0; f < 4; f++)
      send_request(make_pair(0, 0, 0, 1 << 16, 2 << 16, f[0], 0, 1 << 16, 0,
                             1 << 16, 2 << 16, f[1]));
    // Radial push with negative and positive offsets.
    send_request(make_pair(0, 0, 0, 1 << 16, 8 << 16, 0, 32'h0001_8000, 0, 32'hffff_8000,
                           1 << 16, 8 << 16, 0));
    send_request(make_pair(32'hffff_0000, 0, 0, 1 << 16, 8 << 16, 1, 0, 0, 0,
                           1 << 16, 8 << 16, 0));
    // Equal vertical and radial depth, which picks vertical.
    send_request(make_pair(0, 0, 0, 1 << 16, 1 << 16, 0, 1 << 16, 0, 0,
                           1 << 16, 1 << 16, 0));
    // Touching vertically and touching radially: both are misses.
    send_request(make_pair(0, 0, 0, 1 << 16, 1 << 16, 0, 0, 1 << 16, 0,
                           1 << 16, 1 << 16, 0));
    send_request(make_pair(0, 0, 0, 1 << 16, 1 << 16, 0, 2 << 16, 0, 0,
                           1 << 16, 1 << 16, 0));
    // Zero sizes.
    send_request(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Extreme coordinates and lengths.
    send_request(make_pair(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, '1, '1, 0,
                           32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, '1, '1, 0));
    send_request(make_pair(32'h8000_0000, 32'h8000_0000, 0, '1, '1, 1,
                           32'h8000_0000, 32'h7fff_ffff, 0, '1, '1, 0));
    send_request(make_pair(32'h8000_0000, 32'h8000_0000, 0, '1, '1, 0,
                           32'h7fff_ffff, 32'h8000_0000, 0, '1, '1, 1));
    send_request(make_pair(32'hffff_ffff, 32'h7fff_ffff, 32'hffff_ffff, '1, '1, 0,
                           32'h0, 32'h7fff_ffff, 32'h0, '1, '1, 1));

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 33 : (phase == 1) ? 77 : 0;
      for (int n = 0; n < 150; n++) send_request(rand_pair());
    end
    start <= 1'b0;

    waited = 0;
    while (sb.pending.size() != 0 && waited < 10 * LATENCY) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("cylinder_collision_mtv_core verification clean");
    end else begin
      $display("cylinder_collision_mtv_core verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake or lost results.
  initial begin
    #2ms;
    $display("cylinder_collision_mtv_core verification failed");
    $finish;
  end
endmodule

[files.f]
rtl/ccm_pkg.sv
rtl/ccm_sqrt_pipe.sv
rtl/ccm_div_pipe.sv
rtl/cylinder_collision_mtv_core.sv
tb/cylinder_collision_mtv_core_tb.sv
